FILE: rtl/core/ketq_pkg.sv
package ketq_pkg;

  // Sizes of the held-key table and the event queue.
  localparam int unsigned MAX_KEYS    = 8;
  localparam int unsigned QUEUE_DEPTH = 16;

  // Index and count widths derived from the sizes.
  localparam int unsigned KIDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned KCNT_W = $clog2(MAX_KEYS + 1);
  localparam int unsigned QIDX_W = $clog2(QUEUE_DEPTH);

  // Field widths of an item.
  localparam int unsigned CODE_W = 8;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned ENTRY_W = KIND_W + CODE_W;

  // Reset value of the ignore threshold.
  localparam logic [CODE_W-1:0] IGNORE_RESET = 8'd2;

  typedef enum logic [1:0] {
    OP_KEY_DOWN = 2'd0,
    OP_KEY_UP   = 2'd1,
    OP_TICK     = 2'd2,
    OP_DRAIN    = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESSED  = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_HELD     = 2'd2,
    KIND_ERROR    = 2'd3
  } kind_t;

endpackage

FILE: rtl/core/key_event_tracker_queue.sv
// Key event tracker with an ordered held-key table and an event queue.
//
// Input items arrive on the s_ channel: s_tuser carries the opcode (key down,
// key up, tick, drain) and s_tdata the key code. Result items leave on the m_
// channel: m_tuser carries the event kind, m_tdata the key code and m_tlast
// marks the final result of one input item; only a drain and an error give
// results. The ignore threshold is written through cfg_we and cfg_data.
//
// One item is taken at a time. The table and the queue sit in memories with
// one write and one read port and a registered read, so each entry is read
// and then compared or written. A key down scans the table, then appends the
// key; a key up scans up to the match, then moves each later entry down; a
// tick queues a held event per entry and a drain hands each queued event to
// the output while the output flows. An ignored key, an empty tick or drain
// and an item while halted leave the block idle; an error goes on to the error state.
//
// Reset clears the counts and the halt flag and sets the threshold to 2;
// memory contents are left as they are. An error emits one result and halts
// the block: later items are taken and dropped until reset. When the receiver
// stalls, the output register holds its item and the drain or error waits.
module key_event_tracker_queue
  import ketq_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CODE_W-1:0]   cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [7:0] key_code
  input  logic [1:0]          s_tuser,   // [1:0] opcode
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [7:0]          m_tdata,   // [7:0] event_code
  output logic [KIND_W-1:0]   m_tuser,   // [1:0] event_kind
  output logic                m_tlast
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_SCAN_RD   = 11'b000_0000_0010,
    ST_SCAN_CMP  = 11'b000_0000_0100,
    ST_DOWN_END  = 11'b000_0000_1000,
    ST_SHIFT_RD  = 11'b000_0001_0000,
    ST_SHIFT_WR  = 11'b000_0010_0000,
    ST_TICK_RD   = 11'b000_0100_0000,
    ST_TICK_WR   = 11'b000_1000_0000,
    ST_DRAIN_RD  = 11'b001_0000_0000,
    ST_DRAIN_OUT = 11'b010_0000_0000,
    ST_ERR       = 11'b100_0000_0000
  } state_t;

  // Control registers.
  state_t              state, state_next;
  logic [KCNT_W-1:0]   held_count, held_count_next;
  logic [QIDX_W-1:0]   event_count, event_count_next;
  logic                halted, halted_next;
  logic [CODE_W-1:0]   ignore_below;
  logic [KIDX_W-1:0]   hidx, hidx_next;
  logic [QIDX_W-1:0]   eidx, eidx_next;

  // Captured item.
  op_t                 op, op_next;
  logic [CODE_W-1:0]   code, code_next;

  // Output register.
  logic                m_tvalid_next, m_tlast_next;
  logic [CODE_W-1:0]   m_tdata_next;
  logic [KIND_W-1:0]   m_tuser_next;

  // Memories and their ports.
  logic [CODE_W-1:0]   held_mem [MAX_KEYS];
  logic [ENTRY_W-1:0]  ev_mem   [QUEUE_DEPTH];
  logic [CODE_W-1:0]   held_rd;
  logic [ENTRY_W-1:0]  ev_rd;
  logic                held_we;
  logic [KIDX_W-1:0]   held_waddr;
  logic [CODE_W-1:0]   held_wdata;
  logic                ev_we;
  logic [ENTRY_W-1:0]  ev_wdata;

  logic                accept, out_free, last_key, last_ev, queue_open;

  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign last_key   = (KCNT_W'(hidx) + KCNT_W'(1)) == held_count;
  assign last_ev    = (eidx + QIDX_W'(1)) == event_count;
  assign queue_open = event_count != QIDX_W'(QUEUE_DEPTH - 1);

  // Held-key table: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (held_we) begin
      held_mem[held_waddr] <= held_wdata;
    end
    held_rd <= held_mem[hidx];
  end

  // Event queue: one write and one registered read per cycle.
  // An event pushed onto a full queue is dropped.
  always_ff @(posedge clk) begin
    if (ev_we) begin
      ev_mem[event_count] <= ev_wdata;
    end
    ev_rd <= ev_mem[eidx];
  end

  // Sequencer for table scans, shifts, ticks and drains.
  always_comb begin
    state_next       = state;
    held_count_next  = held_count;
    event_count_next = event_count;
    halted_next      = halted;
    hidx_next        = hidx;
    eidx_next        = eidx;
    op_next          = op;
    code_next        = code;
    m_tvalid_next    = m_tvalid && !m_tready;
    m_tdata_next     = m_tdata;
    m_tuser_next     = m_tuser;
    m_tlast_next     = m_tlast;
    held_we          = 1'b0;
    held_waddr       = hidx;
    held_wdata       = code;
    ev_we            = 1'b0;
    ev_wdata         = {KIND_PRESSED, code};

    case (state)
      ST_IDLE: begin
        if (accept && !halted) begin
          op_next   = op_t'(s_tuser);
          code_next = s_tdata;
          hidx_next = '0;
          eidx_next = '0;
          case (op_t'(s_tuser))
            OP_KEY_DOWN: begin
              if (s_tdata >= ignore_below) begin
                state_next = (held_count == '0) ? ST_DOWN_END : ST_SCAN_RD;
              end
            end
            OP_KEY_UP: begin
              state_next = (held_count == '0) ? ST_ERR : ST_SCAN_RD;
            end
            OP_TICK: begin
              if (held_count != '0) begin
                state_next = ST_TICK_RD;
              end
            end
            default: begin
              if (event_count != '0) begin
                state_next = ST_DRAIN_RD;
              end
            end
          endcase
        end
      end

      ST_SCAN_RD: begin
        state_next = ST_SCAN_CMP;
      end

      // Compare one table entry against the captured key.
      ST_SCAN_CMP: begin
        if (held_rd == code) begin
          if (op == OP_KEY_DOWN) begin
            state_next = ST_ERR;
          end else begin
            ev_we    = queue_open;
            ev_wdata = {KIND_RELEASED, code};
            if (queue_open) begin
              event_count_next = event_count + QIDX_W'(1);
            end
            if (last_key) begin
              held_count_next = held_count - KCNT_W'(1);
              state_next      = ST_IDLE;
            end else begin
              hidx_next  = hidx + KIDX_W'(1);
              state_next = ST_SHIFT_RD;
            end
          end
        end else if (last_key) begin
          state_next = (op == OP_KEY_DOWN) ? ST_DOWN_END : ST_ERR;
        end else begin
          hidx_next  = hidx + KIDX_W'(1);
          state_next = ST_SCAN_RD;
        end
      end

      // No duplicate found: append the key unless the table is full.
      ST_DOWN_END: begin
        if (held_count == KCNT_W'(MAX_KEYS)) begin
          state_next = ST_ERR;
        end else begin
          held_we         = 1'b1;
          held_waddr      = KIDX_W'(held_count);
          held_count_next = held_count + KCNT_W'(1);
          ev_we           = queue_open;
          if (queue_open) begin
            event_count_next = event_count + QIDX_W'(1);
          end
          state_next = ST_IDLE;
        end
      end

      ST_SHIFT_RD: begin
        state_next = ST_SHIFT_WR;
      end

      // Move one entry down by one place to close the gap.
      ST_SHIFT_WR: begin
        held_we    = 1'b1;
        held_waddr = hidx - KIDX_W'(1);
        held_wdata = held_rd;
        if (last_key) begin
          held_count_next = held_count - KCNT_W'(1);
          state_next      = ST_IDLE;
        end else begin
          hidx_next  = hidx + KIDX_W'(1);
          state_next = ST_SHIFT_RD;
        end
      end

      ST_TICK_RD: begin
        state_next = ST_TICK_WR;
      end

      // Queue a held event for one table entry.
      ST_TICK_WR: begin
        ev_we    = queue_open;
        ev_wdata = {KIND_HELD, held_rd};
        if (queue_open) begin
          event_count_next = event_count + QIDX_W'(1);
        end
        if (last_key) begin
          state_next = ST_IDLE;
        end else begin
          hidx_next  = hidx + KIDX_W'(1);
          state_next = ST_TICK_RD;
        end
      end

      ST_DRAIN_RD: begin
        state_next = ST_DRAIN_OUT;
      end

      // Hand one queued event to the output register.
      ST_DRAIN_OUT: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tuser_next  = ev_rd[ENTRY_W-1:CODE_W];
          m_tdata_next  = ev_rd[CODE_W-1:0];
          m_tlast_next  = last_ev;
          if (last_ev) begin
            event_count_next = '0;
            state_next       = ST_IDLE;
          end else begin
            eidx_next  = eidx + QIDX_W'(1);
            state_next = ST_DRAIN_RD;
          end
        end
      end

      // Emit the error result and halt.
      ST_ERR: begin
        if (out_free) begin
          m_tvalid_next = 1'b1;
          m_tuser_next  = KIND_ERROR;
          m_tdata_next  = code;
          m_tlast_next  = 1'b1;
          halted_next   = 1'b1;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      held_count  <= '0;
      event_count <= '0;
      halted      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state       <= state_next;
      held_count  <= held_count_next;
      event_count <= event_count_next;
      halted      <= halted_next;
      m_tvalid    <= m_tvalid_next;
    end
  end

  // Threshold register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_below <= IGNORE_RESET;
    end else if (cfg_we) begin
      ignore_below <= cfg_data;
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk) begin
    hidx    <= hidx_next;
    eidx    <= eidx_next;
    op      <= op_next;
    code    <= code_next;
    m_tdata <= m_tdata_next;
    m_tuser <= m_tuser_next;
    m_tlast <= m_tlast_next;
  end

  // The queue never counts past its emittable depth.
  assert property (@(posedge clk) disable iff (rst)
    event_count <= QIDX_W'(QUEUE_DEPTH - 1))
    else $error("event count beyond queue depth");

  // The table never holds more keys than it has entries.
  assert property (@(posedge clk) disable iff (rst)
    held_count <= KCNT_W'(MAX_KEYS))
    else $error("held count beyond table size");

  // An error result on the output means the block has halted.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_ERROR) |-> halted)
    else $error("error result without halt");

  // Once halted, the block stays halted until reset.
  assert property (@(posedge clk) disable iff (rst)
    halted |=> halted)
    else $error("halt flag cleared without reset");

endmodule

FILE: dv/key_event_tracker_queue_tb.sv
module key_event_tracker_queue_tb
  import ketq_pkg::*;
();

  localparam int SETTLE_CYCLES = 64;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_REPORTS   = 10;
  localparam int DIRECTED_N    = 25;

  // One result item as it leaves the block.
  typedef struct packed {
    kind_t             kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } event_item_t;

  // One row of the directed table. Where typed is set, the row carries its
  // own results (up to two); otherwise the key model supplies them.
  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0] code;
    logic              typed;
    logic [1:0]        n_typed;
    kind_t             kind0;
    logic [CODE_W-1:0] code0;
    kind_t             kind1;
    logic [CODE_W-1:0] code1;
  } directed_row_t;

  directed_row_t directed_rows [DIRECTED_N] = '{
    // Drain right after reset, then keys below, at and far above the threshold.
    '{OP_DRAIN,    8'd0,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd0,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd1,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd2,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd255, 1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_DRAIN,    8'd0,   1'b1, 2'd2, KIND_PRESSED,  8'd2,   KIND_PRESSED, 8'd255},
    '{OP_KEY_UP,   8'd2,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_TICK,     8'd0,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_DRAIN,    8'd0,   1'b1, 2'd2, KIND_RELEASED, 8'd2,   KIND_HELD,    8'd255},
    // Fill the table, then overflow the queue with two ticks and a key up.
    '{OP_KEY_DOWN, 8'd10,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd20,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd30,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd40,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd50,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd60,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_DOWN, 8'd70,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_TICK,     8'd0,   1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_TICK,     8'd0,   1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_UP,   8'd40,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_DRAIN,    8'd0,   1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    // Release the first and the last table entry, then drain twice.
    '{OP_KEY_UP,   8'd255, 1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_KEY_UP,   8'd70,  1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_TICK,     8'd0,   1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_DRAIN,    8'd0,   1'b0, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0},
    '{OP_DRAIN,    8'd0,   1'b1, 2'd0, KIND_PRESSED,  8'd0,   KIND_PRESSED, 8'd0}
  };

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [CODE_W-1:0] cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [7:0]        s_tdata;   // [7:0] key_code
  logic [1:0]        s_tuser;   // [1:0] opcode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;   // [7:0] event_code
  logic [KIND_W-1:0] m_tuser;   // [1:0] event_kind
  logic              m_tlast;

  int send_idle_pct = 17;
  int recv_idle_pct = 60;
  int failures      = 0;
  int quiet_cycles  = 0;

  // Results still owed by the block, oldest first.
  event_item_t expected_events [$];

  // Key model state.
  logic [CODE_W-1:0]  held_keys [MAX_KEYS];
  int                 held_n;
  logic [ENTRY_W-1:0] pending_events [QUEUE_DEPTH];
  int                 pending_n;
  bit                 halted;
  logic [CODE_W-1:0]  ignore_level;

  key_event_tracker_queue uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void reset_key_model();
    held_n       = 0;
    pending_n    = 0;
    halted       = 1'b0;
    ignore_level = IGNORE_RESET;
  endfunction

  function automatic void post_result(kind_t kind, logic [CODE_W-1:0] code, logic last,
                                      bit keep);
    event_item_t item;
    item.kind = kind;
    item.code = code;
    item.last = last;
    if (keep) begin
      expected_events = {expected_events, item};
    end
  endfunction

  // The queue keeps one spare slot; an event written there is never emitted.
  function automatic void queue_key_event(kind_t kind, logic [CODE_W-1:0] code);
    if (pending_n < QUEUE_DEPTH - 1) begin
      pending_events[pending_n] = {kind, code};
      pending_n++;
    end else begin
      pending_events[QUEUE_DEPTH-1] = {kind, code};
    end
  endfunction

  function automatic int held_index(logic [CODE_W-1:0] code);
    for (int i = 0; i < held_n; i++) begin
      if (held_keys[i] == code) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Applies one accepted item to the key model and posts its results.
  function automatic void predict_key_item(op_t op, logic [CODE_W-1:0] code, bit keep);
    int idx;
    int n;
    if (halted) begin
      return;
    end
    case (op)
      OP_KEY_DOWN: begin
        if (code >= ignore_level) begin
          if (held_index(code) >= 0 || held_n >= MAX_KEYS) begin
            halted = 1'b1;
            post_result(KIND_ERROR, code, 1'b1, keep);
          end else begin
            held_keys[held_n] = code;
            held_n++;
            queue_key_event(KIND_PRESSED, code);
          end
        end
      end
      OP_KEY_UP: begin
        idx = held_index(code);
        if (idx < 0) begin
          halted = 1'b1;
          post_result(KIND_ERROR, code, 1'b1, keep);
        end else begin
          queue_key_event(KIND_RELEASED, code);
          for (int j = idx; j + 1 < held_n; j++) begin
            held_keys[j] = held_keys[j+1];
          end
          held_n--;
        end
      end
      OP_TICK: begin
        for (int j = 0; j < held_n; j++) begin
          queue_key_event(KIND_HELD, held_keys[j]);
        end
      end
      default: begin
        n = pending_n;
        for (int j = 0; j < n; j++) begin
          post_result(kind_t'(pending_events[j][ENTRY_W-1:CODE_W]),
                      pending_events[j][CODE_W-1:0], j + 1 == n, keep);
        end
        pending_n = 0;
      end
    endcase
  endfunction

  // A key code at or above the threshold that is not held, or -1.
  function automatic int fresh_code();
    int code;
    for (int tries = 0; tries < 32; tries++) begin
      code = $urandom_range(255, ignore_level);
      if (held_index(8'(code)) < 0) begin
        return code;
      end
    end
    return -1;
  endfunction

  // Offers one item, holding it until the block takes it.
  task automatic send_item(op_t op, logic [CODE_W-1:0] code, bit keep);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= code;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    predict_key_item(op, code, keep);
  endtask

  task automatic wait_for_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_events.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The block must be idle: no result owed and no silent item still running.
  task automatic write_threshold(logic [CODE_W-1:0] value);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    ignore_level  = value;
  endtask

  // Mostly legal key sequences with random codes, plus ignored keys as noise.
  // Illegal sequences halt the block, so they are kept for the very end.
  task automatic run_random(int count);
    op_t op;
    logic [CODE_W-1:0] code;
    int fresh;
    int r;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(29) == 0) begin
        wait_for_results();
      end
      r     = $urandom_range(99);
      fresh = fresh_code();
      code  = 8'($urandom);
      if (r < 10) begin
        if (ignore_level > 0) begin
          op   = OP_KEY_DOWN;
          code = 8'($urandom_range(ignore_level - 1));
        end else begin
          op = OP_TICK;
        end
      end else if (r < 67) begin
        if ((r < 42 || held_n == 0) && held_n < MAX_KEYS && fresh >= 0) begin
          op   = OP_KEY_DOWN;
          code = 8'(fresh);
        end else if (held_n > 0) begin
          op   = OP_KEY_UP;
          code = held_keys[$urandom_range(held_n - 1)];
        end else begin
          op = OP_TICK;
        end
      end else if (r < 82) begin
        op = OP_TICK;
      end else begin
        op = OP_DRAIN;
      end
      send_item(op, code, 1'b1);
    end
  endtask

  // Stimulus.
  initial begin
    directed_row_t row;
    int pick;
    int code;
    rst      <= 1'b1;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_KEY_DOWN;
    reset_key_model();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_N; i++) begin
      row = directed_rows[i];
      send_item(row.op, row.code, !row.typed);
      if (row.typed && row.n_typed >= 1) begin
        post_result(row.kind0, row.code0, row.n_typed == 1, 1'b1);
      end
      if (row.typed && row.n_typed == 2) begin
        post_result(row.kind1, row.code1, 1'b1, 1'b1);
      end
    end

    write_threshold(8'd0);
    run_random(60);

    send_idle_pct = 60;
    recv_idle_pct = 17;
    write_threshold(8'($urandom_range(200, 3)));
    run_random(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_threshold(8'd255);
    run_random(25);
    write_threshold(8'($urandom_range(200, 1)));
    run_random(45);

    // Close with one protocol error, then items that the halted block drops.
    pick = $urandom_range(2);
    if (pick == 0) begin
      while (held_n < MAX_KEYS && !halted) begin
        send_item(OP_KEY_DOWN, 8'(fresh_code()), 1'b1);
      end
      send_item(OP_KEY_DOWN, 8'(fresh_code()), 1'b1);
    end else if (pick == 1) begin
      code = -1;
      for (int i = 0; i < held_n; i++) begin
        if (held_keys[i] >= ignore_level) begin
          code = held_keys[i];
        end
      end
      if (code < 0) begin
        code = fresh_code();
        send_item(OP_KEY_DOWN, 8'(code), 1'b1);
      end
      send_item(OP_KEY_DOWN, 8'(code), 1'b1);
    end else begin
      code = $urandom_range(255);
      while (held_index(8'(code)) >= 0) begin
        code = $urandom_range(255);
      end
      send_item(OP_KEY_UP, 8'(code), 1'b1);
    end
    for (int i = 0; i < 6; i++) begin
      send_item(op_t'($urandom_range(3)), 8'($urandom), 1'b1);
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("[key_event_tracker_queue] OK");
    end else begin
      $display("[key_event_tracker_queue] ERROR");
    end
    $finish;
  end

  // Receiver stalls.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest one owed.
  always @(posedge clk) begin : check_results
    event_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS) begin
          $display("unexpected result: kind %0d code %0d last %0b",
                   m_tuser, m_tdata, m_tlast);
        end
      end else begin
        want = expected_events.pop_front();
        if (m_tuser !== want.kind || m_tdata !== want.code || m_tlast !== want.last) begin
          failures++;
          if (failures <= MAX_REPORTS) begin
            $display("mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                     want.kind, want.code, want.last, m_tuser, m_tdata, m_tlast);
          end
        end
      end
    end
  end

  // End the run when nothing moves on either side for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("[key_event_tracker_queue] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
